// ===== rtl/tqs_pkg.sv =====
// tqs_pkg: types, constants and helpers shared by the timer queue scheduler
// used by tqs_cell, tqs_rbuf and timer_queue_scheduler_top
package tqs_pkg;

  localparam int TimerSlotsDef = 16;
  localparam int MaxFiresDef   = 64;
  localparam int TIME_W        = 48;
  localparam int PER_W         = 32;
  localparam int SLOT_W        = 8;   // holds any slot index up to 256 slots
  localparam int WAIT_W        = 49;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_DEL  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FIRE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_SETTLE,
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_LOAD,
    S_SHOW
  } state_e;

  // command broadcast to every cell, acted on by the addressed one
  typedef struct packed {
    cmd_e              op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  repeats;
  } cell_cmd_t;

  // running earliest timer and lowest free slot handed along the row
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] expiry;
    logic [SLOT_W-1:0] slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
  } cand_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic       fired;
  } res_t;

  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                  input logic [PER_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W-PER_W+1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/tqs_cell.sv =====
// tqs_cell: one timer slot and one step of the earliest-expiry search
// depends on tqs_pkg
module tqs_cell import tqs_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  cand_t     cand_i,
  output cand_t     cand_o,
  output logic      active_o
);

  logic              active_q, active_d;
  logic [TIME_W-1:0] exp_q, exp_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [PER_W-1:0]  rep_q, rep_d;
  cand_t             cand_q, cand_d;
  logic              hit;

  assign hit = (cmd_i.slot == SLOT_W'(IDX));

  always_comb begin
    active_d = active_q;
    exp_d    = exp_q;
    per_d    = per_q;
    rep_d    = rep_q;
    if (hit) begin
      case (cmd_i.op)
        CMD_WRITE: begin
          active_d = 1'b1;
          exp_d    = cmd_i.expiry;
          per_d    = cmd_i.period;
          rep_d    = cmd_i.repeats;
        end
        CMD_CLEAR: active_d = 1'b0;
        CMD_FIRE: begin
          if (rep_q == PER_W'(1)) begin
            active_d = 1'b0;
          end else begin
            exp_d = sat_add48(exp_q, per_q);
            if (rep_q != '0) rep_d = rep_q - PER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // strict compare keeps the lower slot on equal expiry
  always_comb begin
    cand_d = cand_i;
    if (active_q && (!cand_i.valid || exp_q < cand_i.expiry)) begin
      cand_d.valid  = 1'b1;
      cand_d.expiry = exp_q;
      cand_d.slot   = SLOT_W'(IDX);
    end
    if (!cand_i.free_found && !active_q) begin
      cand_d.free_found = 1'b1;
      cand_d.free_slot  = SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cand_q   <= '0;
    end else begin
      active_q <= active_d;
      cand_q   <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    per_q <= per_d;
    rep_q <= rep_d;
  end

  assign cand_o   = cand_q;
  assign active_o = active_q;

endmodule

// ===== rtl/tqs_rbuf.sv =====
// tqs_rbuf: result buffer holding the items of one input until they are sent
// depends on tqs_pkg
module tqs_rbuf import tqs_pkg::*; #(
  parameter int DEPTH = MaxFiresDef,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  res_t          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output res_t          rd_data_o
);

  res_t mem [DEPTH];
  res_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/timer_queue_scheduler_top.sv =====
// timer_queue_scheduler_top: timer queue built as a row of slot cells
// depends on tqs_pkg, tqs_cell, tqs_rbuf
//
//   channel   signals                                         direction
//   in        in_valid_i/in_ready_o, kind, now, interval,      into block
//             repeat, slot id
//   out       out_valid_o/out_ready_i, status, slot, fired,    out of block
//             last, next wait
//
// the row hands the running minimum one cell per cycle, so after every state change
// the block waits in S_SETTLE for the row to settle before the next decision
// add/delete: S_EXEC, S_SETTLE, S_WAIT after the accept, then S_LOAD, S_SHOW per item
// tick: S_EXEC and S_SETTLE per fire, then S_WAIT, then S_LOAD, S_SHOW per item
// in_ready_o rises the cycle after the last result item is taken
// after reset the row settles in S_SETTLE before in_ready_o rises
// results of an item are buffered and sent once next_wait_ms is known; a stall
// on out holds the item and keeps in_ready_o low
module timer_queue_scheduler_top import tqs_pkg::*; #(
  parameter int TIMER_SLOTS        = TimerSlotsDef,
  parameter int MAX_FIRES_PER_TICK = MaxFiresDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic [TIME_W-1:0]        now_ms_i,
  input  logic [PER_W-1:0]         interval_ms_i,
  input  logic [PER_W-1:0]         repeat_count_i,
  input  logic [3:0]               slot_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [3:0]               timer_slot_o,
  output logic                     fired_o,
  output logic                     last_o,
  output logic signed [WAIT_W-1:0] next_wait_ms_o
);

  localparam int AW  = (MAX_FIRES_PER_TICK > 1) ? $clog2(MAX_FIRES_PER_TICK) : 1;
  localparam int NW  = $clog2(MAX_FIRES_PER_TICK + 1);
  localparam int CW  = $clog2(TIMER_SLOTS + 1);

  state_e            state_q, state_d, ret_q, ret_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     nres_q, nres_d;
  logic [AW-1:0]     rd_q, rd_d;
  logic [1:0]        kind_q;
  logic [TIME_W-1:0] now_q;
  logic [PER_W-1:0]  int_q, rep_q;
  logic [3:0]        sid_q;
  logic signed [WAIT_W-1:0] wait_q, wait_d;

  cell_cmd_t         cmd;
  cand_t             cand [TIMER_SLOTS+1];
  cand_t             best;
  logic [TIMER_SLOTS-1:0] active_vec;
  logic              sid_hit;
  logic              wr_en, rd_en;
  res_t              wr_data, rd_data;
  logic              in_acc;

  assign cand[0] = '0;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    tqs_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .cand_i  (cand[g]),
      .cand_o  (cand[g+1]),
      .active_o(active_vec[g])
    );
  end

  assign best = cand[TIMER_SLOTS];

  always_comb begin
    sid_hit = 1'b0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (SLOT_W'(i) == {{(SLOT_W-4){1'b0}}, sid_q}) sid_hit = active_vec[i];
    end
  end

  tqs_rbuf #(.DEPTH(MAX_FIRES_PER_TICK), .AW(AW)) u_rbuf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(nres_q[AW-1:0]),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_q),
    .rd_data_o(rd_data)
  );

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cnt_d      = cnt_q;
    nres_d     = nres_q;
    rd_d       = rd_q;
    wait_d     = wait_q;
    cmd        = '0;
    cmd.op     = CMD_NONE;
    wr_en      = 1'b0;
    wr_data    = '0;
    wr_data.status = ST_OK;
    rd_en      = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_SETTLE: begin
        if (cnt_q <= CW'(1)) state_d = ret_q;
        else cnt_d = cnt_q - CW'(1);
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          nres_d  = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_e'(kind_q))
          KIND_ADD: begin
            wr_en = 1'b1;
            if (best.free_found) begin
              cmd.op      = CMD_WRITE;
              cmd.slot    = best.free_slot;
              cmd.expiry  = sat_add48(now_q, int_q);
              cmd.period  = int_q;
              cmd.repeats = rep_q;
              wr_data.slot = best.free_slot[3:0];
            end else begin
              wr_data.status = ST_FULL;
            end
            nres_d  = NW'(1);
            cnt_d   = CW'(TIMER_SLOTS);
            ret_d   = S_WAIT;
            state_d = S_SETTLE;
          end
          KIND_DEL: begin
            wr_en        = 1'b1;
            wr_data.slot = sid_q;
            if (sid_hit) begin
              cmd.op   = CMD_CLEAR;
              cmd.slot = {{(SLOT_W-4){1'b0}}, sid_q};
            end else begin
              wr_data.status = ST_NOT_FOUND;
            end
            nres_d  = NW'(1);
            cnt_d   = CW'(TIMER_SLOTS);
            ret_d   = S_WAIT;
            state_d = S_SETTLE;
          end
          default: begin
            // tick and the unused kind code
            if (nres_q < NW'(MAX_FIRES_PER_TICK) && best.valid &&
                now_q >= best.expiry) begin
              cmd.op        = CMD_FIRE;
              cmd.slot      = best.slot;
              wr_en         = 1'b1;
              wr_data.slot  = best.slot[3:0];
              wr_data.fired = 1'b1;
              nres_d        = nres_q + NW'(1);
              cnt_d         = CW'(TIMER_SLOTS);
              ret_d         = S_EXEC;
              state_d       = S_SETTLE;
            end else begin
              if (nres_q == '0) begin
                wr_en  = 1'b1;
                nres_d = NW'(1);
              end
              state_d = S_WAIT;
            end
          end
        endcase
      end
      S_WAIT: begin
        if (!best.valid) wait_d = '1;
        else if (best.expiry > now_q) wait_d = {1'b0, best.expiry - now_q};
        else wait_d = '0;
        rd_d    = '0;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        rd_en   = 1'b1;
        state_d = S_SHOW;
      end
      S_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_o) begin
            state_d = S_IDLE;
          end else begin
            rd_d    = rd_q + AW'(1);
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SETTLE;
      ret_q   <= S_IDLE;
      cnt_q   <= CW'(TIMER_SLOTS);
      nres_q  <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      nres_q  <= nres_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wait_q <= wait_d;
    if (in_acc) begin
      kind_q <= kind_i;
      now_q  <= now_ms_i;
      int_q  <= interval_ms_i;
      rep_q  <= repeat_count_i;
      sid_q  <= slot_id_i;
    end
  end

  assign status_o       = rd_data.status;
  assign timer_slot_o   = rd_data.slot;
  assign fired_o        = rd_data.fired;
  assign last_o         = ({{(NW-AW){1'b0}}, rd_q} + NW'(1)) == nres_q;
  assign next_wait_ms_o = wait_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while results pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready held after accept");

  a_fire_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (status_o == ST_OK)) else $error("fire with bad status");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NW'(MAX_FIRES_PER_TICK)) else $error("result count beyond cap");

  a_show_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nres_q != '0)) else $error("result sent with empty buffer");

endmodule
